// ----- hdl/hpic_pkg.sv -----
// Shared types, register codes and constants of the heated press interlock controller.
package hpic_pkg;

  // Timestamp arithmetic width; elapsed times wrap modulo 2**TIME_BITS.
  localparam int TIME_BITS = 32;

  localparam int TEMP_W = 12;
  localparam int HAND_W = 10;
  localparam int DIST_W = 17;
  localparam int TOL_W  = 12;
  localparam int MS_W   = 16;
  localparam int NOW_W  = 32;
  localparam int LED_W  = 8;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 17;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HEAT_ON_BELOW  = 3'd0,
    CFG_HEAT_OFF_AT    = 3'd1,
    CFG_HAND_THRESHOLD = 3'd2,
    CFG_RETRACT_TOL    = 3'd3,
    CFG_REST_DISTANCE  = 3'd4,
    CFG_OPEN_TIME      = 3'd5,
    CFG_COOLDOWN_TIME  = 3'd6
  } cfg_idx_e;

  typedef logic [TIME_BITS-1:0] time_t;

  typedef struct packed {
    logic [TEMP_W-1:0] heat_on_below;
    logic [TEMP_W-1:0] heat_off_at;
    logic [HAND_W-1:0] hand_threshold;
    logic [TOL_W-1:0]  retract_tolerance;
    logic [DIST_W-1:0] rest_distance;
    logic [MS_W-1:0]   open_time_ms;
    logic [MS_W-1:0]   cooldown_time_ms;
  } cfg_t;

  localparam logic [TEMP_W-1:0] RST_HEAT_ON_BELOW  = 12'd720;
  localparam logic [TEMP_W-1:0] RST_HEAT_OFF_AT    = 12'd740;
  localparam logic [HAND_W-1:0] RST_HAND_THRESHOLD = 10'd900;
  localparam logic [TOL_W-1:0]  RST_RETRACT_TOL    = 12'd32;
  localparam logic [DIST_W-1:0] RST_REST_DISTANCE  = 17'd0;
  localparam logic [MS_W-1:0]   RST_OPEN_TIME      = 16'd2000;
  localparam logic [MS_W-1:0]   RST_COOLDOWN_TIME  = 16'd10000;

  typedef struct packed {
    logic [TEMP_W-1:0] temperature_q2;
    logic              button_pressed;
    logic              bread_present;
    logic [HAND_W-1:0] hand_level;
    logic              distance_valid;
    logic [DIST_W-1:0] distance_q4;
    logic [NOW_W-1:0]  now_ms;
  } sample_t;

  typedef struct packed {
    logic [LED_W-1:0] green;
    logic [LED_W-1:0] blue;
  } led_t;

  typedef struct packed {
    logic             heater_drive;
    logic             valve_drive;
    logic             ram_retracted;
    logic             hand_detected;
    logic [LED_W-1:0] led_green;
    logic [LED_W-1:0] led_blue;
  } result_t;

  localparam led_t LED_RST = '{green: 8'd255, blue: 8'd255};

  // Colour ramp breakpoints in quarter degrees
  localparam logic [TEMP_W-1:0] RAMP_T0 = 12'd400;
  localparam logic [TEMP_W-1:0] RAMP_T1 = 12'd600;
  localparam logic [TEMP_W-1:0] RAMP_T2 = 12'd740;

  localparam logic [15:0] G_MID_BASE  = 16'd51000;  // 255 * 200
  localparam logic [15:0] G_MID_SLOPE = 16'd155;

  // Reciprocal multipliers, exact over the operand ranges used
  localparam logic [17:0] DIV400_M  = 18'd167773;
  localparam int          DIV400_SH = 26;
  localparam logic [14:0] DIV25_M   = 15'd10486;
  localparam int          DIV25_SH  = 18;
  localparam logic [10:0] DIV7_M    = 11'd1171;
  localparam int          DIV7_SH   = 13;

endpackage

// ----- hdl/hpic_if.sv -----
// Sample and result channel interfaces of the heated press interlock controller.
interface hpic_sample_if;
  import hpic_pkg::*;

  logic              valid;
  logic              ready;
  logic [TEMP_W-1:0] temperature_q2;
  logic              button_pressed;
  logic              bread_present;
  logic [HAND_W-1:0] hand_level;
  logic              distance_valid;
  logic [DIST_W-1:0] distance_q4;
  logic [NOW_W-1:0]  now_ms;

  modport source (
    output valid, temperature_q2, button_pressed, bread_present, hand_level,
           distance_valid, distance_q4, now_ms,
    input  ready
  );

  modport sink (
    input  valid, temperature_q2, button_pressed, bread_present, hand_level,
           distance_valid, distance_q4, now_ms,
    output ready
  );
endinterface

interface hpic_result_if;
  import hpic_pkg::*;

  logic             valid;
  logic             ready;
  logic             heater_drive;
  logic             valve_drive;
  logic             ram_retracted;
  logic             hand_detected;
  logic [LED_W-1:0] led_green;
  logic [LED_W-1:0] led_blue;

  modport source (
    output valid, heater_drive, valve_drive, ram_retracted, hand_detected,
           led_green, led_blue,
    input  ready
  );

  modport sink (
    input  valid, heater_drive, valve_drive, ram_retracted, hand_detected,
           led_green, led_blue,
    output ready
  );
endinterface

// ----- hdl/hpic_cfg_regs.sv -----
// Configuration register file, written through a plain indexed write port.
module hpic_cfg_regs (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             we_i,
  input  logic [hpic_pkg::CFG_IDX_W-1:0]   idx_i,
  input  logic [hpic_pkg::CFG_DATA_W-1:0]  wdata_i,
  output hpic_pkg::cfg_t                   cfg_o
);
  import hpic_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (we_i) begin
      case (idx_i)
        CFG_HEAT_ON_BELOW:  cfg_d.heat_on_below     = wdata_i[TEMP_W-1:0];
        CFG_HEAT_OFF_AT:    cfg_d.heat_off_at       = wdata_i[TEMP_W-1:0];
        CFG_HAND_THRESHOLD: cfg_d.hand_threshold    = wdata_i[HAND_W-1:0];
        CFG_RETRACT_TOL:    cfg_d.retract_tolerance = wdata_i[TOL_W-1:0];
        CFG_REST_DISTANCE:  cfg_d.rest_distance     = wdata_i[DIST_W-1:0];
        CFG_OPEN_TIME:      cfg_d.open_time_ms      = wdata_i[MS_W-1:0];
        CFG_COOLDOWN_TIME:  cfg_d.cooldown_time_ms  = wdata_i[MS_W-1:0];
        default:            cfg_d = cfg_q;  // unused index, write dropped
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.heat_on_below     <= RST_HEAT_ON_BELOW;
      cfg_q.heat_off_at       <= RST_HEAT_OFF_AT;
      cfg_q.hand_threshold    <= RST_HAND_THRESHOLD;
      cfg_q.retract_tolerance <= RST_RETRACT_TOL;
      cfg_q.rest_distance     <= RST_REST_DISTANCE;
      cfg_q.open_time_ms      <= RST_OPEN_TIME;
      cfg_q.cooldown_time_ms  <= RST_COOLDOWN_TIME;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- hdl/hpic_colour.sv -----
// Piecewise-linear temperature to green/blue LED ramp, divisions by reciprocal multiply.
module hpic_colour (
  input  logic [hpic_pkg::TEMP_W-1:0] temp_i,
  input  hpic_pkg::led_t              led_i,
  output hpic_pkg::led_t              led_o
);
  import hpic_pkg::*;

  logic [TEMP_W-1:0] d_blue, d_mid, d_low;
  logic [16:0]       x_blue;   // 255 * (400 - t)
  logic [34:0]       p_blue;
  logic [15:0]       x_mid;    // 255*200 - 155*(t - 400)
  logic [12:0]       y_mid;    // x_mid / 8, then / 25
  logic [26:0]       p_mid;
  logic [9:0]        x_low;    // 5 * (740 - t), then / 7
  logic [20:0]       p_low;

  always_comb begin
    d_blue = RAMP_T0 - temp_i;
    x_blue = {d_blue[8:0], 8'b0} - {8'b0, d_blue[8:0]};
    p_blue = 35'(x_blue) * 35'(DIV400_M);

    d_mid  = temp_i - RAMP_T0;
    x_mid  = G_MID_BASE - (16'(d_mid[7:0]) * G_MID_SLOPE);
    y_mid  = x_mid[15:3];
    p_mid  = 27'(y_mid) * 27'(DIV25_M);

    d_low  = RAMP_T2 - temp_i;
    x_low  = {d_low[7:0], 2'b00} + {2'b00, d_low[7:0]};
    p_low  = 21'(x_low) * 21'(DIV7_M);

    led_o = led_i;  // above the top breakpoint both levels hold
    if (temp_i <= RAMP_T0) begin
      led_o.green = 8'd255;
      led_o.blue  = p_blue[DIV400_SH +: LED_W];
    end else if (temp_i <= RAMP_T1) begin
      led_o.green = p_mid[DIV25_SH +: LED_W];
      led_o.blue  = '0;
    end else if (temp_i <= RAMP_T2) begin
      led_o.green = p_low[DIV7_SH +: LED_W];
      led_o.blue  = '0;
    end
  end

endmodule

// ----- hdl/heated_press_interlock_controller.sv -----
// Top level: sample register, interlock and heater logic, result register.
//
//  channel    dir  handshake       payload
//  sample_i   in   valid/ready     temperature, button, bread, hand, distance, now_ms
//  result_o   out  valid/ready     heater, valve, retracted, hand, led green/blue
//  cfg_*_i    in   cfg_we_i only   7 registers by index, 17-bit data
//
// One sample per cycle sustained while the result side accepts; a result passes
// through the sample register, then the result register. All state updates in the
// single pass from sample register to result register. Reset restores the
// register defaults and the state (heater off, valve closed, retracted, LEDs
// full). A stalled result holds the output register; one more sample waits in
// the sample register before ready drops.
module heated_press_interlock_controller (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  hpic_sample_if.sink                     sample_i,
  hpic_result_if.source                   result_o,
  input  logic                            cfg_we_i,
  input  logic [hpic_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [hpic_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);
  import hpic_pkg::*;

  cfg_t    cfg;
  sample_t in_q;
  logic    in_valid_q;
  result_t result_q, result_d;
  logic    out_valid_q;
  logic    advance;

  logic    heater_q, heater_d;
  logic    valve_q, valve_d;
  logic    retract_q, retract_d;
  time_t   open_stamp_q, open_stamp_d;
  time_t   cool_stamp_q, cool_stamp_d;
  led_t    led_q, led_d;

  time_t             now_t;
  logic [DIST_W-1:0] dist_diff;
  logic              hand;
  logic              open_now, close_now;

  hpic_cfg_regs u_cfg_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (cfg_we_i),
    .idx_i   (cfg_idx_i),
    .wdata_i (cfg_wdata_i),
    .cfg_o   (cfg)
  );

  hpic_colour u_colour (
    .temp_i (in_q.temperature_q2),
    .led_i  (led_q),
    .led_o  (led_d)
  );

  // Result register takes the pass when empty or draining this cycle.
  assign advance        = in_valid_q && (!out_valid_q || result_o.ready);
  assign sample_i.ready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (sample_i.ready) begin
      in_valid_q <= sample_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sample_i.valid && sample_i.ready) begin
      in_q.temperature_q2 <= sample_i.temperature_q2;
      in_q.button_pressed <= sample_i.button_pressed;
      in_q.bread_present  <= sample_i.bread_present;
      in_q.hand_level     <= sample_i.hand_level;
      in_q.distance_valid <= sample_i.distance_valid;
      in_q.distance_q4    <= sample_i.distance_q4;
      in_q.now_ms         <= sample_i.now_ms;
    end
  end

  always_comb begin
    now_t = TIME_BITS'(in_q.now_ms);
    hand  = in_q.hand_level <= cfg.hand_threshold;

    dist_diff = (in_q.distance_q4 >= cfg.rest_distance)
              ? in_q.distance_q4 - cfg.rest_distance
              : cfg.rest_distance - in_q.distance_q4;
    retract_d = in_q.distance_valid ? (dist_diff <= DIST_W'(cfg.retract_tolerance))
                                    : retract_q;

    // hysteresis, turn-on compare wins
    if (in_q.temperature_q2 < cfg.heat_on_below) begin
      heater_d = 1'b1;
    end else if (in_q.temperature_q2 >= cfg.heat_off_at) begin
      heater_d = 1'b0;
    end else begin
      heater_d = heater_q;
    end

    open_now = !valve_q && in_q.button_pressed
             && ((now_t - cool_stamp_q) > TIME_BITS'(cfg.cooldown_time_ms))
             && in_q.bread_present && !hand && !heater_d && retract_d;
    // a valve opened in this pass is not yet in valve_q and cannot close
    close_now = valve_q && ((now_t - open_stamp_q) > TIME_BITS'(cfg.open_time_ms));

    valve_d      = close_now ? 1'b0 : (valve_q || open_now);
    open_stamp_d = open_now  ? now_t : open_stamp_q;
    cool_stamp_d = close_now ? now_t : cool_stamp_q;

    result_d.heater_drive  = heater_d;
    result_d.valve_drive   = valve_d;
    result_d.ram_retracted = retract_d;
    result_d.hand_detected = hand;
    result_d.led_green     = led_d.green;
    result_d.led_blue      = led_d.blue;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      heater_q     <= 1'b0;
      valve_q      <= 1'b0;
      retract_q    <= 1'b1;
      open_stamp_q <= '0;
      cool_stamp_q <= '0;
      led_q        <= LED_RST;
      out_valid_q  <= 1'b0;
    end else begin
      if (advance) begin
        heater_q     <= heater_d;
        valve_q      <= valve_d;
        retract_q    <= retract_d;
        open_stamp_q <= open_stamp_d;
        cool_stamp_q <= cool_stamp_d;
        led_q        <= led_d;
        out_valid_q  <= 1'b1;
      end else if (result_o.ready) begin
        out_valid_q  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      result_q <= result_d;
    end
  end

  assign result_o.valid         = out_valid_q;
  assign result_o.heater_drive  = result_q.heater_drive;
  assign result_o.valve_drive   = result_q.valve_drive;
  assign result_o.ram_retracted = result_q.ram_retracted;
  assign result_o.hand_detected = result_q.hand_detected;
  assign result_o.led_green     = result_q.led_green;
  assign result_o.led_blue      = result_q.led_blue;

  // valve only opens with heater off and ram retracted
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(valve_q) |-> (!heater_q && retract_q))
    else $error("valve opened against interlock");

  // opening stamps the time of the sample that opened it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(valve_q) |-> (open_stamp_q == $past(now_t)))
    else $error("open stamp does not match opening sample");

  // without a pass through the logic, no state moves
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> ($stable(valve_q) && $stable(heater_q) && $stable(led_q)
                  && $stable(cool_stamp_q)))
    else $error("state changed without a sample pass");

  // a held sample is never dropped
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !advance) |=> in_valid_q)
    else $error("pending sample lost");

endmodule

// ----- verif/tb_heated_press_interlock_controller.sv -----
// Self-checking testbench for the heated press interlock controller.
module tb_heated_press_interlock_controller;
  timeunit 1ns;
  timeprecision 1ps;

  import hpic_pkg::*;

  localparam int WATCHDOG_CYCLES = 3000;
  localparam int DRAIN_CYCLES    = 4;
  localparam int BACKLOG_CYCLES  = 200;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED = 3'd7;

  localparam cfg_t CFG_DEFAULTS = '{
    heat_on_below:     RST_HEAT_ON_BELOW,
    heat_off_at:       RST_HEAT_OFF_AT,
    hand_threshold:    RST_HAND_THRESHOLD,
    retract_tolerance: RST_RETRACT_TOL,
    rest_distance:     RST_REST_DISTANCE,
    open_time_ms:      RST_OPEN_TIME,
    cooldown_time_ms:  RST_COOLDOWN_TIME
  };

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  hpic_sample_if sample_bus ();
  hpic_result_if result_bus ();

  heated_press_interlock_controller dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .sample_i    (sample_bus),
    .result_o    (result_bus),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  // Controller state as the predictor sees it
  cfg_t             press_cfg       = CFG_DEFAULTS;
  logic             heater_state    = 1'b0;
  logic             valve_state     = 1'b0;
  logic             retracted_state = 1'b1;
  time_t            valve_opened_at = '0;
  time_t            valve_closed_at = '0;
  logic [LED_W-1:0] green_level     = 8'd255;
  logic [LED_W-1:0] blue_level      = 8'd255;

  result_t pending_outputs[$];

  int          errors         = 0;
  int          n_sent         = 0;
  int          n_checked      = 0;
  int          openings       = 0;
  int          tx_idle_pct    = 31;
  int          rx_idle_pct    = 31;
  int          rx_hold_cycles = 0;
  int          stall_cycles   = 0;
  time_t       now_cursor     = '0;
  int unsigned step_max       = 16;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic result_t press_step(sample_t s);
    result_t     r;
    int unsigned t;
    int unsigned gap;
    logic        hand;
    t = s.temperature_q2;
    if (t <= RAMP_T0) begin
      green_level = 8'd255;
      blue_level  = LED_W'((255 * 400 - 255 * t) / 400);
    end else if (t <= RAMP_T1) begin
      green_level = LED_W'((255 * 200 - 155 * (t - 400)) / 200);
      blue_level  = 8'd0;
    end else if (t <= RAMP_T2) begin
      green_level = LED_W'((100 * 140 - 100 * (t - 600)) / 140);
      blue_level  = 8'd0;
    end
    hand = s.hand_level <= press_cfg.hand_threshold;
    if (s.distance_valid) begin
      gap = (s.distance_q4 >= press_cfg.rest_distance) ?
            s.distance_q4 - press_cfg.rest_distance :
            press_cfg.rest_distance - s.distance_q4;
      retracted_state = gap <= press_cfg.retract_tolerance;
    end
    // turn-on compare wins when the thresholds overlap
    if (s.temperature_q2 < press_cfg.heat_on_below) heater_state = 1'b1;
    else if (s.temperature_q2 >= press_cfg.heat_off_at) heater_state = 1'b0;
    if (!valve_state && s.button_pressed &&
        time_t'(s.now_ms - valve_closed_at) > press_cfg.cooldown_time_ms &&
        s.bread_present && !hand && !heater_state && retracted_state) begin
      valve_state     = 1'b1;
      valve_opened_at = s.now_ms;
      openings++;
    end
    if (valve_state && time_t'(s.now_ms - valve_opened_at) > press_cfg.open_time_ms) begin
      valve_state     = 1'b0;
      valve_closed_at = s.now_ms;
    end
    r.heater_drive  = heater_state;
    r.valve_drive   = valve_state;
    r.ram_retracted = retracted_state;
    r.hand_detected = hand;
    r.led_green     = green_level;
    r.led_blue      = blue_level;
    return r;
  endfunction

  function automatic sample_t mk_sample(int unsigned temp, bit btn, bit bread,
                                        int unsigned hand, bit dv, int unsigned range_q4,
                                        time_t now);
    sample_t s;
    s.temperature_q2 = TEMP_W'(temp);
    s.button_pressed = btn;
    s.bread_present  = bread;
    s.hand_level     = HAND_W'(hand);
    s.distance_valid = dv;
    s.distance_q4    = DIST_W'(range_q4);
    s.now_ms         = now;
    return s;
  endfunction

  function automatic void compare_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      errors++;
    end
  endfunction

  task automatic send_sample(sample_t s);
    if ($urandom_range(99) < tx_idle_pct) begin
      sample_bus.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < tx_idle_pct);
    end
    sample_bus.valid          <= 1'b1;
    sample_bus.temperature_q2 <= s.temperature_q2;
    sample_bus.button_pressed <= s.button_pressed;
    sample_bus.bread_present  <= s.bread_present;
    sample_bus.hand_level     <= s.hand_level;
    sample_bus.distance_valid <= s.distance_valid;
    sample_bus.distance_q4    <= s.distance_q4;
    sample_bus.now_ms         <= s.now_ms;
    do @(posedge clk_i); while (!sample_bus.ready);
    pending_outputs.push_back(press_step(s));
    n_sent++;
  endtask

  // Leaves the write enable high; the caller drops it after the last write.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(posedge clk_i);
    case (idx)
      CFG_HEAT_ON_BELOW:  press_cfg.heat_on_below     = data[TEMP_W-1:0];
      CFG_HEAT_OFF_AT:    press_cfg.heat_off_at       = data[TEMP_W-1:0];
      CFG_HAND_THRESHOLD: press_cfg.hand_threshold    = data[HAND_W-1:0];
      CFG_RETRACT_TOL:    press_cfg.retract_tolerance = data[TOL_W-1:0];
      CFG_REST_DISTANCE:  press_cfg.rest_distance     = data[DIST_W-1:0];
      CFG_OPEN_TIME:      press_cfg.open_time_ms      = data[MS_W-1:0];
      CFG_COOLDOWN_TIME:  press_cfg.cooldown_time_ms  = data[MS_W-1:0];
      default: ;
    endcase
    // timestamps advance so that a few samples fall in each open and cooldown window
    step_max = (press_cfg.open_time_ms + press_cfg.cooldown_time_ms) / 6 + 3;
  endtask

  task automatic load_config(cfg_t c);
    write_reg(CFG_HEAT_ON_BELOW,  c.heat_on_below);
    write_reg(CFG_HEAT_OFF_AT,    c.heat_off_at);
    write_reg(CFG_HAND_THRESHOLD, c.hand_threshold);
    write_reg(CFG_RETRACT_TOL,    c.retract_tolerance);
    write_reg(CFG_REST_DISTANCE,  c.rest_distance);
    write_reg(CFG_OPEN_TIME,      c.open_time_ms);
    write_reg(CFG_COOLDOWN_TIME,  c.cooldown_time_ms);
    cfg_we <= 1'b0;
  endtask

  task automatic drain_results();
    sample_bus.valid <= 1'b0;
    while (n_checked < n_sent) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Mostly press attempts that satisfy the interlock, the rest unconstrained noise
  task automatic send_random(int n);
    sample_t     s;
    int unsigned lo;
    int          d;
    repeat (n) begin
      s.temperature_q2 = TEMP_W'($urandom_range(4095));
      s.button_pressed = 1'($urandom_range(1));
      s.bread_present  = 1'($urandom_range(1));
      s.hand_level     = HAND_W'($urandom_range(1023));
      s.distance_valid = 1'($urandom_range(1));
      s.distance_q4    = DIST_W'($urandom_range(131071));
      if ($urandom_range(99) < 80) begin
        lo = (press_cfg.heat_on_below > press_cfg.heat_off_at) ?
             press_cfg.heat_on_below : press_cfg.heat_off_at;
        if ($urandom_range(99) < 85) s.temperature_q2 = TEMP_W'($urandom_range(4095, lo));
        s.button_pressed = $urandom_range(99) < 60;
        s.bread_present  = $urandom_range(99) < 95;
        if (press_cfg.hand_threshold != 10'h3FF && $urandom_range(99) < 90)
          s.hand_level = HAND_W'($urandom_range(1023, press_cfg.hand_threshold + 1));
        s.distance_valid = $urandom_range(99) < 90;
        d = int'($urandom_range(press_cfg.retract_tolerance));
        if ($urandom_range(1)) d = -d;
        d = int'(press_cfg.rest_distance) + d;
        if (d < 0 || d > 131071) d = 2 * int'(press_cfg.rest_distance) - d;
        s.distance_q4 = DIST_W'(d);
      end
      if ($urandom_range(99) < 2) now_cursor = $urandom;
      else now_cursor += $urandom_range(step_max);
      s.now_ms = now_cursor;
      send_sample(s);
    end
  endtask

  task automatic test_colour_ramp();
    send_sample(mk_sample(0,    0, 0, 0,    1, 131071, 32'd0));
    send_sample(mk_sample(1,    1, 1, 1023, 0, 0,      32'hFFFF_FFFF));
    send_sample(mk_sample(400,  0, 1, 512,  1, 32,     32'd5));
    send_sample(mk_sample(401,  0, 0, 901,  1, 33,     32'd6));
    send_sample(mk_sample(600,  0, 1, 900,  0, 7,      32'd7));
    send_sample(mk_sample(601,  0, 1, 1023, 1, 0,      32'd8));
    send_sample(mk_sample(740,  0, 0, 1023, 1, 65536,  32'd9));
    send_sample(mk_sample(741,  0, 1, 1023, 1, 0,      32'd10));
    send_sample(mk_sample(4095, 0, 1, 1023, 1, 0,      32'd11));
  endtask

  task automatic test_valve_interlock();
    // first opening waits out the cooldown measured from time zero
    send_sample(mk_sample(800, 1, 1, 1023, 1, 0,    32'd10000));
    send_sample(mk_sample(800, 1, 0, 1023, 1, 0,    32'd10001));
    send_sample(mk_sample(800, 1, 1, 900,  1, 0,    32'd10001));
    send_sample(mk_sample(800, 1, 1, 1023, 1, 33,   32'd10001));
    send_sample(mk_sample(800, 1, 1, 1023, 0, 5000, 32'd10001));
    send_sample(mk_sample(800, 1, 1, 1023, 1, 32,   32'd10001));
    send_sample(mk_sample(800, 0, 0, 0,    1, 0,    32'd12001));
    send_sample(mk_sample(800, 0, 1, 1023, 1, 0,    32'd12002));
    send_sample(mk_sample(800, 1, 1, 1023, 1, 0,    32'd22002));
    send_sample(mk_sample(800, 1, 1, 1023, 1, 0,    32'd22003));
    send_sample(mk_sample(800, 0, 1, 1023, 1, 0,    32'd24004));
    // heater on, then held on inside the hysteresis band, then off
    send_sample(mk_sample(700, 1, 1, 1023, 1, 0,    32'd40000));
    send_sample(mk_sample(730, 1, 1, 1023, 1, 0,    32'd40001));
    send_sample(mk_sample(740, 1, 1, 1023, 1, 0,    32'd40002));
    // idle sample just before the wrap, reopen on the far side of it
    send_sample(mk_sample(800, 0, 1, 1023, 1, 0,    32'hFFFF_FFF0));
    send_sample(mk_sample(800, 1, 1, 1023, 1, 0,    32'd9984));
    send_sample(mk_sample(800, 1, 1, 1023, 1, 0,    32'd9985));
    now_cursor = 32'd9985;
  endtask

  task automatic test_threshold_overlap();
    cfg_t c;
    drain_results();
    c = CFG_DEFAULTS;
    c.heat_on_below = 12'd800;
    c.heat_off_at   = 12'd700;
    load_config(c);
    send_sample(mk_sample(750, 0, 1, 1023, 1, 0, now_cursor));
    send_sample(mk_sample(650, 0, 1, 1023, 1, 0, now_cursor));
    send_sample(mk_sample(850, 0, 1, 1023, 1, 0, now_cursor));
  endtask

  task automatic test_config_extremes();
    cfg_idx_e r;
    drain_results();
    load_config('0);
    send_random(40);
    drain_results();
    // all-ones data is wider than most registers; the unused index must change nothing
    r = r.first();
    do begin
      write_reg(r, '1);
      r = r.next();
    end while (r != r.first());
    write_reg(CFG_IDX_UNUSED, '0);
    cfg_we <= 1'b0;
    send_random(40);
    drain_results();
    load_config(CFG_DEFAULTS);
    send_random(40);
  endtask

  task automatic test_random_configs();
    cfg_t c;
    for (int p = 0; p < 8; p++) begin
      drain_results();
      c.heat_on_below     = TEMP_W'($urandom_range(900, 300));
      c.heat_off_at       = TEMP_W'(($urandom_range(99) < 80)
                                    ? c.heat_on_below + $urandom_range(60)
                                    : $urandom_range(4095));
      c.hand_threshold    = HAND_W'($urandom_range(1023));
      c.retract_tolerance = TOL_W'(($urandom_range(99) < 70) ? $urandom_range(200)
                                                             : $urandom_range(4095));
      c.rest_distance     = DIST_W'($urandom_range(131071));
      c.open_time_ms      = MS_W'($urandom_range(40));
      c.cooldown_time_ms  = MS_W'($urandom_range(100));
      load_config(c);
      // first phase runs with both sides streaming back to back
      tx_idle_pct = (p == 0) ? 0 : 31;
      rx_idle_pct = (p == 0) ? 0 : 31;
      send_random(70);
    end
  endtask

  task automatic test_backpressure();
    tx_idle_pct    = 0;
    rx_hold_cycles = BACKLOG_CYCLES;
    send_random(40);
    // sender pauses until every outstanding result has arrived
    drain_results();
    send_random(20);
    tx_idle_pct = 31;
  endtask

  initial begin : receiver
    result_bus.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rx_hold_cycles > 0) begin
        result_bus.ready <= 1'b0;
        repeat (rx_hold_cycles) @(posedge clk_i);
        rx_hold_cycles = 0;
      end else begin
        result_bus.ready <= $urandom_range(99) >= rx_idle_pct;
      end
    end
  end

  always @(posedge clk_i) begin : result_check
    result_t want;
    if (result_bus.valid && result_bus.ready) begin
      n_checked++;
      if (pending_outputs.size() == 0) begin
        $error("result transfer with no sample outstanding");
        errors++;
      end else begin
        want = pending_outputs.pop_front();
        compare_field("heater_drive",  want.heater_drive,  result_bus.heater_drive);
        compare_field("valve_drive",   want.valve_drive,   result_bus.valve_drive);
        compare_field("ram_retracted", want.ram_retracted, result_bus.ram_retracted);
        compare_field("hand_detected", want.hand_detected, result_bus.hand_detected);
        compare_field("led_green",     want.led_green,     result_bus.led_green);
        compare_field("led_blue",      want.led_blue,      result_bus.led_blue);
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    if ((sample_bus.valid && sample_bus.ready) || (result_bus.valid && result_bus.ready))
      stall_cycles = 0;
    else
      stall_cycles++;
    if (stall_cycles >= WATCHDOG_CYCLES) begin
      $error("no transfer for %0d cycles, %0d results outstanding",
             stall_cycles, pending_outputs.size());
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    rst_ni                    <= 1'b0;
    cfg_we                    <= 1'b0;
    cfg_idx                   <= '0;
    cfg_wdata                 <= '0;
    sample_bus.valid          <= 1'b0;
    sample_bus.temperature_q2 <= '0;
    sample_bus.button_pressed <= 1'b0;
    sample_bus.bread_present  <= 1'b0;
    sample_bus.hand_level     <= '0;
    sample_bus.distance_valid <= 1'b0;
    sample_bus.distance_q4    <= '0;
    sample_bus.now_ms         <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_colour_ramp();
    test_valve_interlock();
    test_threshold_overlap();
    test_config_extremes();
    test_random_configs();
    test_backpressure();
    drain_results();

    $display("Covered: colour ramp breakpoints, interlock and cooldown, hysteresis, time wrap,");
    $display("register extremes and output back-pressure; %0d samples, %0d valve openings",
             n_sent, openings);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
